[rtl/zssf_pkg.sv]
package zssf_pkg;

  // Stream and block framing constants
  localparam logic [7:0]  ZLIB_CMF        = 8'h78;
  localparam logic [7:0]  ZLIB_FLG        = 8'h01;
  localparam int          BLK_LEN_W       = 16;
  localparam logic [BLK_LEN_W-1:0] MAX_BLOCK_BYTES = 16'hFFFF;
  localparam int          STREAM_LEN_W    = 32;
  localparam int          ADLER_W         = 16;
  localparam logic [ADLER_W:0] ADLER_MOD  = 17'd65521;
  localparam logic [7:0]  BFINAL_LAST     = 8'h01;
  localparam logic [7:0]  BFINAL_MORE     = 8'h00;

  // One accepted item yields at most this many output bytes
  localparam int RUN_MAX   = 10;
  localparam int RUN_IDX_W = $clog2(RUN_MAX);
  localparam logic [RUN_IDX_W-1:0] IDX_HDR_ONLY = RUN_IDX_W'(1);
  localparam logic [RUN_IDX_W-1:0] IDX_HDR_TRL  = RUN_IDX_W'(5);
  localparam logic [RUN_IDX_W-1:0] BLK_HDR_LEN  = RUN_IDX_W'(5);
  localparam logic [RUN_IDX_W-1:0] TRAILER_LEN  = RUN_IDX_W'(4);

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } opcode_e;

  // Bytes caused by one item; entry 0 goes out first
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_IDX_W-1:0]    last_idx;
    logic                    done;
    logic                    ovr;
  } run_t;

endpackage

[rtl/zssf_framer_core.sv]
module zssf_framer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  logic                                opcode_i,
  input  logic [7:0]                          data_byte_i,
  input  logic [zssf_pkg::STREAM_LEN_W-1:0]   stream_length_i,
  output zssf_pkg::run_t                      run_o
);
  import zssf_pkg::*;

  logic [ADLER_W-1:0]      sum_low_q, sum_low_d;
  logic [ADLER_W-1:0]      sum_high_q, sum_high_d;
  logic [STREAM_LEN_W-1:0] left_q, left_d;
  logic [BLK_LEN_W-1:0]    blk_rem_q, blk_rem_d;

  logic [ADLER_W:0]        low_sum, high_sum;
  logic [ADLER_W-1:0]      low_new, high_new;
  logic [BLK_LEN_W-1:0]    blk_len, blk_nlen;
  logic                    blk_final;
  logic                    need_hdr, need_trl;
  logic [7:0]              bfinal;
  logic [RUN_IDX_W-1:0]    base_idx;

  // Adler-32 update, each half reduced by one conditional subtract
  always_comb begin
    low_sum  = {1'b0, sum_low_q} + {{(ADLER_W-8+1){1'b0}}, data_byte_i};
    low_new  = (low_sum >= ADLER_MOD) ? ADLER_W'(low_sum - ADLER_MOD) : low_sum[ADLER_W-1:0];
    high_sum = {1'b0, sum_high_q} + {1'b0, low_new};
    high_new = (high_sum >= ADLER_MOD) ? ADLER_W'(high_sum - ADLER_MOD)
                                       : high_sum[ADLER_W-1:0];
  end

  // Stored-block header fields
  always_comb begin
    blk_final = (left_q <= STREAM_LEN_W'(MAX_BLOCK_BYTES));
    blk_len   = blk_final ? left_q[BLK_LEN_W-1:0] : MAX_BLOCK_BYTES;
    blk_nlen  = ~blk_len;
    bfinal    = blk_final ? BFINAL_LAST : BFINAL_MORE;
    need_hdr  = (blk_rem_q == '0);
    need_trl  = (left_q == STREAM_LEN_W'(1));
  end

  // Run builder and next state
  always_comb begin
    run_o      = '0;
    sum_low_d  = sum_low_q;
    sum_high_d = sum_high_q;
    left_d     = left_q;
    blk_rem_d  = blk_rem_q;
    base_idx   = '0;
    if (opcode_i == OP_START) begin
      run_o.bytes[0] = ZLIB_CMF;
      run_o.bytes[1] = ZLIB_FLG;
      sum_low_d      = ADLER_W'(1);
      sum_high_d     = '0;
      left_d         = stream_length_i;
      blk_rem_d      = '0;
      if (stream_length_i == '0) begin
        // empty stream: trailer of the initial checksum
        run_o.bytes[5] = 8'h01;
        run_o.last_idx = IDX_HDR_TRL;
        run_o.done     = 1'b1;
      end else begin
        run_o.last_idx = IDX_HDR_ONLY;
      end
    end else if (left_q == '0) begin
      // no open stream: drop the byte
      run_o.ovr      = 1'b1;
      run_o.last_idx = '0;
    end else begin
      if (need_hdr) begin
        run_o.bytes[0] = bfinal;
        run_o.bytes[1] = blk_len[7:0];
        run_o.bytes[2] = blk_len[15:8];
        run_o.bytes[3] = blk_nlen[7:0];
        run_o.bytes[4] = blk_nlen[15:8];
        base_idx       = BLK_HDR_LEN;
        blk_rem_d      = blk_len - BLK_LEN_W'(1);
      end else begin
        blk_rem_d      = blk_rem_q - BLK_LEN_W'(1);
      end
      run_o.bytes[base_idx] = data_byte_i;
      if (need_trl) begin
        run_o.bytes[base_idx + RUN_IDX_W'(1)] = high_new[15:8];
        run_o.bytes[base_idx + RUN_IDX_W'(2)] = high_new[7:0];
        run_o.bytes[base_idx + RUN_IDX_W'(3)] = low_new[15:8];
        run_o.bytes[base_idx + RUN_IDX_W'(4)] = low_new[7:0];
        run_o.last_idx = base_idx + TRAILER_LEN;
        run_o.done     = 1'b1;
      end else begin
        run_o.last_idx = base_idx;
      end
      sum_low_d  = low_new;
      sum_high_d = high_new;
      left_d     = left_q - STREAM_LEN_W'(1);
    end
  end

  // Stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q  <= ADLER_W'(1);
      sum_high_q <= '0;
      left_q     <= '0;
      blk_rem_q  <= '0;
    end else if (take_i) begin
      sum_low_q  <= sum_low_d;
      sum_high_q <= sum_high_d;
      left_q     <= left_d;
      blk_rem_q  <= blk_rem_d;
    end
  end

endmodule

[rtl/zssf_run_emitter.sv]
module zssf_run_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  zssf_pkg::run_t run_i,
  input  logic           load_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o,
  output logic           stream_done_o,
  output logic           overrun_o
);
  import zssf_pkg::*;

  run_t                 run_q, run_d;
  logic                 busy_q, busy_d;
  logic [RUN_IDX_W-1:0] idx_q, idx_d;
  logic                 at_last, xfer;

  assign at_last       = (idx_q == run_q.last_idx);
  assign xfer          = busy_q && out_ready_i;
  assign free_o        = !busy_q || (out_ready_i && at_last);
  assign out_valid_o   = busy_q;
  assign out_byte_o    = run_q.bytes[idx_q];
  assign last_of_run_o = at_last;
  assign stream_done_o = run_q.done && at_last;
  assign overrun_o     = run_q.ovr;

  // Step through the held run; a new run loads when idle or as the last byte leaves
  always_comb begin
    run_d  = run_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (xfer) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + RUN_IDX_W'(1);
      end
    end
    if (load_i) begin
      run_d  = run_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

endmodule

[rtl/zlib_stored_stream_framer_top.sv]
// The first byte of an item's result run is valid in the cycle after the input transfer.
// One output byte per cycle while out_ready is high; an item causing n bytes (1 to 10) holds
//   the output until all n have left; the next item is taken in the cycle its last byte leaves.
// Single-byte items therefore flow at one per cycle; the output register sets the pace.
// Reset: no stream open, Adler-32 = 1, stream_length = 0, output empty.
module zlib_stored_stream_framer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        stream_done_o,
  output logic        overrun_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] stream_length_i
);
  import zssf_pkg::*;

  logic [STREAM_LEN_W-1:0] stream_length_q;
  run_t                    run;
  logic                    free, take;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = free;
  assign take        = in_valid_i && free;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stream_length_q <= stream_length_i;
    end
  end

  zssf_framer_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .opcode_i        (opcode_i),
    .data_byte_i     (data_byte_i),
    .stream_length_i (stream_length_q),
    .run_o           (run)
  );

  zssf_run_emitter u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .run_i         (run),
    .load_i        (take),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o),
    .overrun_o     (overrun_o)
  );

  // An accepted item always shows a result next cycle
  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o) else $error("accepted item produced no result");

  // A dropped byte is a single zero result
  a_ovr_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overrun_o |-> last_of_run_o && out_byte_o == 8'h00)
    else $error("overrun result malformed");

  // End of stream is always the end of its run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> last_of_run_o && !overrun_o)
    else $error("stream_done not on final byte");

  // No new item while a run still has bytes left
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !in_ready_o)
    else $error("input taken mid-run");

endmodule

[tb/zssf_tb_pkg.sv]
`timescale 1ns / 100ps

package zssf_tb_pkg;
  import zssf_pkg::*;

  // One byte of the framed stream as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       ovr;
  } zbyte_t;

  // Predicts the zlib byte stream and checks it in order
  class zlib_frame_scoreboard;
    zbyte_t      expected_q[$];
    int unsigned errors;
    logic [31:0] len_reg;
    logic [31:0] total_len;
    logic [31:0] bytes_taken;
    logic [31:0] sum_low;
    logic [31:0] sum_high;
    logic [15:0] blk_left;
    bit          open;

    function new();
      errors      = 0;
      len_reg     = '0;
      total_len   = '0;
      bytes_taken = '0;
      sum_low     = 32'd1;
      sum_high    = '0;
      blk_left    = '0;
      open        = 1'b0;
    endfunction

    function void note_length(logic [31:0] v);
      len_reg = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push(logic [7:0] b, logic done, logic ovr);
      zbyte_t e;
      e.data = b;
      e.last = 1'b0;
      e.done = done;
      e.ovr  = ovr;
      expected_q.insert(expected_q.size(), e);
    endfunction

    // Adler-32 trailer, big-endian, done on the last byte
    function void push_checksum();
      logic [31:0] v;
      v = {sum_high[15:0], sum_low[15:0]};
      push(v[31:24], 1'b0, 1'b0);
      push(v[23:16], 1'b0, 1'b0);
      push(v[15:8], 1'b0, 1'b0);
      push(v[7:0], 1'b1, 1'b0);
    endfunction

    // Expected bytes for one accepted input transfer
    function void note_item(opcode_e op, logic [7:0] b);
      logic [31:0] left;
      logic [31:0] blen;
      int          tail;
      if (op == OP_START) begin
        sum_low     = 32'd1;
        sum_high    = '0;
        bytes_taken = '0;
        blk_left    = '0;
        total_len   = len_reg;
        push(ZLIB_CMF, 1'b0, 1'b0);
        push(ZLIB_FLG, 1'b0, 1'b0);
        if (total_len == 0) begin
          push_checksum();
          open = 1'b0;
        end else begin
          open = 1'b1;
        end
      end else if (!open || bytes_taken >= total_len) begin
        // dropped byte: single flagged result, state untouched
        open = 1'b0;
        push(8'h00, 1'b0, 1'b1);
      end else begin
        // new stored block: BFINAL, LEN, NLEN
        if (blk_left == 0) begin
          left = total_len - bytes_taken;
          blen = (left < 32'(MAX_BLOCK_BYTES)) ? left : 32'(MAX_BLOCK_BYTES);
          push((blen == left) ? BFINAL_LAST : BFINAL_MORE, 1'b0, 1'b0);
          push(blen[7:0], 1'b0, 1'b0);
          push(blen[15:8], 1'b0, 1'b0);
          push(~blen[7:0], 1'b0, 1'b0);
          push(~blen[15:8], 1'b0, 1'b0);
          blk_left = blen[15:0];
        end
        push(b, 1'b0, 1'b0);
        sum_low = sum_low + 32'(b);
        if (sum_low >= 32'(ADLER_MOD)) sum_low = sum_low - 32'(ADLER_MOD);
        sum_high = sum_high + sum_low;
        if (sum_high >= 32'(ADLER_MOD)) sum_high = sum_high - 32'(ADLER_MOD);
        bytes_taken = bytes_taken + 1;
        if (blk_left > 0) blk_left = blk_left - 1;
        if (bytes_taken == total_len) begin
          push_checksum();
          open = 1'b0;
        end
      end
      tail = expected_q.size() - 1;
      expected_q[tail].last = 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t tb_top: mismatch: %s", $time, msg);
    endtask

    // Compare one output transfer with the oldest expected byte
    task check_byte(logic [7:0] data, logic last, logic done, logic ovr);
      zbyte_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected byte %02h", data));
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data)
        report($sformatf("out_byte %02h, want %02h", data, e.data));
      if (last !== e.last)
        report($sformatf("last_of_run %b, want %b (byte %02h)", last, e.last, e.data));
      if (done !== e.done)
        report($sformatf("stream_done %b, want %b (byte %02h)", done, e.done, e.data));
      if (ovr !== e.ovr)
        report($sformatf("overrun %b, want %b (byte %02h)", ovr, e.ovr, e.data));
    endtask
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import zssf_pkg::*;
  import zssf_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int LONG_HOLD      = 60;
  localparam int RANDOM_ITEMS   = 280;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  opcode_e     in_op     = OP_START;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_done;
  logic        out_ovr;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_len   = '0;

  zlib_frame_scoreboard sb = new();

  bit          idle_on   = 1'b1;
  bit          stall_on  = 1'b1;
  int          hold_left = 0;
  int          items_sent = 0;
  logic [31:0] cur_len   = '0;

  zlib_stored_stream_framer_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (in_op),
    .data_byte_i     (in_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_byte_o      (out_byte),
    .last_of_run_o   (out_last),
    .stream_done_o   (out_done),
    .overrun_o       (out_ovr),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .stream_length_i (cfg_len)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Data bytes lean toward FF and 00 to stress the checksum
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0, 1: return 8'hFF;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input opcode_e op, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, b);
    items_sent++;
  endtask

  task automatic send_bytes(input int n);
    repeat (n) send_item(OP_DATA, rand_byte());
  endtask

  // Stop offering and wait out every expected byte plus the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_len   <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.note_length(v);
    cur_len = v;
  endtask

  // Start a stream, reprogramming the length only when it changes
  task automatic open_stream(input logic [31:0] len);
    if (len != cur_len) begin
      drain();
      write_length(len);
    end
    send_item(OP_START, rand_byte());
  endtask

  // Output side: check each transfer, then pick next ready
  initial begin : rx_side
    int gap;
    gap = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_byte(out_byte, out_last, out_done, out_ovr);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 4) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run if no transfer happens for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int          kind;
    logic [31:0] len;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no stream open, empty stream on the reset length
    send_item(OP_DATA, 8'hFF);
    open_stream(32'd0);
    send_item(OP_DATA, 8'h00);
    // single byte: longest run of results, then a late byte
    open_stream(32'd1);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h12);
    // full-size length: first block not final; restart mid-stream
    open_stream(32'hFFFF_FFFF);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h80);
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'h01);
    // exactly one maximal block
    open_stream(32'(MAX_BLOCK_BYTES));
    send_item(OP_DATA, 8'h7F);
    // short stream followed by an overrun
    open_stream(32'd3);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h55);
    send_item(OP_DATA, 8'hAA);
    send_item(OP_DATA, 8'hFE);
    // empty stream on a written zero
    open_stream(32'd0);

    // Random: mostly well-formed streams, some broken ones and noise
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!held && items_sent >= 100) begin
        // long output stall while input keeps coming
        held = 1'b1;
        hold_left = LONG_HOLD;
        send_item(OP_START, rand_byte());
        send_bytes(30);
      end
      if (!paused && items_sent >= 200) begin
        paused = 1'b1;
        drain();
      end
      if (items_sent >= 250) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on  = 1'b1;
        stall_on = 1'b1;
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          repeat ($urandom_range(1, 3))
            send_item(opcode_e'($urandom_range(0, 1)), 8'($urandom));
        end
        1: begin
          // abandoned before its length is reached
          len = $urandom_range(2, 60);
          open_stream(len);
          send_bytes($urandom_range(0, int'(len) - 1));
        end
        2: begin
          len = $urandom_range(1, 20);
          open_stream(len);
          send_bytes(int'(len) + $urandom_range(1, 3));
        end
        3: open_stream(32'd0);
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
          open_stream(len);
          send_bytes(int'(len));
        end
      endcase
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/zssf_pkg.sv
rtl/zssf_framer_core.sv
rtl/zssf_run_emitter.sv
rtl/zlib_stored_stream_framer_top.sv
tb/zssf_tb_pkg.sv
tb/tb_top.sv
